// ===== rtl/core/pss_pkg.sv =====
// Package: types, part table and window match function for the pinyin segmenter.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int PSS_WIN_BYTES  = 4;
  localparam int PSS_WIN_BITS   = 8 * PSS_WIN_BYTES;
  localparam int PSS_PART_COUNT = 57;

  typedef enum logic [1:0] {
    PSS_CLS_ATOM = 2'd0,
    PSS_CLS_INIT = 2'd1,
    PSS_CLS_FIN  = 2'd2,
    PSS_CLS_BOTH = 2'd3
  } pss_class_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] txt;
    pss_class_t  cls;
  } pss_part_t;

  typedef struct packed {
    logic [PSS_WIN_BITS-1:0] win;
    logic [2:0]              fill;
    pss_class_t              prev_class;
    logic                    pend_valid;
    logic [5:0]              pend_head;
    logic                    pend_has_tail;
    logic [5:0]              pend_tail;
  } pss_state_t;

  typedef struct packed {
    logic       syllable_valid;
    logic [5:0] head_part;
    logic       has_tail;
    logic [5:0] tail_part;
    logic       run_last;
  } pss_result_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } pss_find_t;

  localparam pss_state_t PSS_STATE_RST = '{
    win: '0, fill: 3'd0, prev_class: PSS_CLS_ATOM, pend_valid: 1'b0,
    pend_head: 6'd0, pend_has_tail: 1'b0, pend_tail: 6'd0
  };

  localparam pss_part_t PSS_PARTS [PSS_PART_COUNT] = '{
    '{3'd4, 32'("iang"), PSS_CLS_FIN},  '{3'd4, 32'("iong"), PSS_CLS_FIN},
    '{3'd4, 32'("uang"), PSS_CLS_FIN},
    '{3'd3, 32'("ang"), PSS_CLS_BOTH},  '{3'd3, 32'("eng"), PSS_CLS_BOTH},
    '{3'd3, 32'("ian"), PSS_CLS_FIN},   '{3'd3, 32'("iao"), PSS_CLS_FIN},
    '{3'd3, 32'("ing"), PSS_CLS_FIN},   '{3'd3, 32'("ong"), PSS_CLS_FIN},
    '{3'd3, 32'("uai"), PSS_CLS_FIN},   '{3'd3, 32'("uan"), PSS_CLS_FIN},
    '{3'd2, 32'("ai"), PSS_CLS_BOTH},   '{3'd2, 32'("an"), PSS_CLS_BOTH},
    '{3'd2, 32'("ao"), PSS_CLS_BOTH},   '{3'd2, 32'("ch"), PSS_CLS_INIT},
    '{3'd2, 32'("ei"), PSS_CLS_BOTH},   '{3'd2, 32'("en"), PSS_CLS_BOTH},
    '{3'd2, 32'("er"), PSS_CLS_ATOM},   '{3'd2, 32'("ia"), PSS_CLS_FIN},
    '{3'd2, 32'("ie"), PSS_CLS_FIN},    '{3'd2, 32'("in"), PSS_CLS_FIN},
    '{3'd2, 32'("iu"), PSS_CLS_FIN},    '{3'd2, 32'("ou"), PSS_CLS_BOTH},
    '{3'd2, 32'("sh"), PSS_CLS_INIT},   '{3'd2, 32'("ua"), PSS_CLS_FIN},
    '{3'd2, 32'("ue"), PSS_CLS_FIN},    '{3'd2, 32'("ui"), PSS_CLS_FIN},
    '{3'd2, 32'("un"), PSS_CLS_FIN},    '{3'd2, 32'("uo"), PSS_CLS_FIN},
    '{3'd2, 32'("ve"), PSS_CLS_FIN},    '{3'd2, 32'("zh"), PSS_CLS_INIT},
    '{3'd1, 32'("a"), PSS_CLS_BOTH},    '{3'd1, 32'("b"), PSS_CLS_INIT},
    '{3'd1, 32'("c"), PSS_CLS_INIT},    '{3'd1, 32'("d"), PSS_CLS_INIT},
    '{3'd1, 32'("e"), PSS_CLS_BOTH},    '{3'd1, 32'("f"), PSS_CLS_INIT},
    '{3'd1, 32'("g"), PSS_CLS_INIT},    '{3'd1, 32'("h"), PSS_CLS_INIT},
    '{3'd1, 32'("i"), PSS_CLS_FIN},     '{3'd1, 32'("j"), PSS_CLS_INIT},
    '{3'd1, 32'("k"), PSS_CLS_INIT},    '{3'd1, 32'("l"), PSS_CLS_INIT},
    '{3'd1, 32'("m"), PSS_CLS_INIT},    '{3'd1, 32'("n"), PSS_CLS_INIT},
    '{3'd1, 32'("o"), PSS_CLS_BOTH},    '{3'd1, 32'("p"), PSS_CLS_INIT},
    '{3'd1, 32'("q"), PSS_CLS_INIT},    '{3'd1, 32'("r"), PSS_CLS_INIT},
    '{3'd1, 32'("s"), PSS_CLS_INIT},    '{3'd1, 32'("t"), PSS_CLS_INIT},
    '{3'd1, 32'("u"), PSS_CLS_FIN},     '{3'd1, 32'("v"), PSS_CLS_FIN},
    '{3'd1, 32'("w"), PSS_CLS_INIT},    '{3'd1, 32'("x"), PSS_CLS_INIT},
    '{3'd1, 32'("y"), PSS_CLS_INIT},    '{3'd1, 32'("z"), PSS_CLS_INIT}
  };

  // Window byte k sits at win[8k +: 8]; part text is right-justified, first char highest.
  function automatic pss_find_t pss_find(input logic [PSS_WIN_BITS-1:0] win,
                                         input logic [2:0] fill);
    pss_find_t res;
    logic      hit;
    res = '0;
    for (int i = PSS_PART_COUNT - 1; i >= 0; i--) begin
      hit = (PSS_PARTS[i].len <= fill);
      for (int k = 0; k < PSS_WIN_BYTES; k++) begin
        if (k < int'(PSS_PARTS[i].len)) begin
          if (win[8*k +: 8] != PSS_PARTS[i].txt[8*(int'(PSS_PARTS[i].len) - 1 - k) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        res.hit = 1'b1;
        res.idx = 6'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pss_in_if.sv =====
// Interface: input byte channel of the pinyin segmenter.
`timescale 1ns / 1ps

interface pss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/core/pss_out_if.sv =====
// Interface: syllable result channel of the pinyin segmenter.
`timescale 1ns / 1ps

interface pss_out_if;
  logic       valid;
  logic       ready;
  logic       syllable_valid;
  logic [5:0] head_part;
  logic       has_tail;
  logic [5:0] tail_part;
  logic       run_last;

  modport source (output valid, output syllable_valid, output head_part, output has_tail,
                  output tail_part, output run_last, input ready);
  modport sink   (input valid, input syllable_valid, input head_part, input has_tail,
                  input tail_part, input run_last, output ready);
endinterface

// ===== rtl/core/pss_step.sv =====
// Single window match and class update: one table lookup, shift and syllable decision.
`timescale 1ns / 1ps

module pss_step (
  input  pss_pkg::pss_state_t  st_i,
  input  logic                 en,
  output pss_pkg::pss_state_t  st_o,
  output logic                 emit,
  output pss_pkg::pss_result_t res
);

  pss_pkg::pss_find_t  fnd;
  pss_pkg::pss_class_t cls;
  logic [2:0]          used;
  logic                open_new;
  logic                is_fin;
  logic                is_init;

  assign fnd     = pss_pkg::pss_find(st_i.win, st_i.fill);
  assign cls     = pss_pkg::PSS_PARTS[fnd.idx].cls;
  assign is_fin  = (cls == pss_pkg::PSS_CLS_FIN)  || (cls == pss_pkg::PSS_CLS_BOTH);
  assign is_init = (cls == pss_pkg::PSS_CLS_INIT) || (cls == pss_pkg::PSS_CLS_BOTH);

  always_comb begin
    st_o     = st_i;
    emit     = 1'b0;
    res      = '0;
    open_new = 1'b0;
    used     = fnd.hit ? pss_pkg::PSS_PARTS[fnd.idx].len : 3'd1;
    if (en) begin
      if (fnd.hit) begin
        if (st_i.prev_class == pss_pkg::PSS_CLS_INIT) begin
          if (is_fin) begin
            st_o.pend_has_tail = 1'b1;
            st_o.pend_tail     = fnd.idx;
            st_o.prev_class    = pss_pkg::PSS_CLS_ATOM;
          end else begin
            open_new = 1'b1;
          end
        end else if (cls == pss_pkg::PSS_CLS_ATOM || is_init) begin
          open_new = 1'b1;
        end
      end
      if (open_new) begin
        emit               = st_i.pend_valid;
        res.syllable_valid = 1'b1;
        res.head_part      = st_i.pend_head;
        res.has_tail       = st_i.pend_has_tail;
        res.tail_part      = st_i.pend_tail;
        res.run_last       = 1'b0;
        st_o.pend_valid    = 1'b1;
        st_o.pend_head     = fnd.idx;
        st_o.pend_has_tail = 1'b0;
        st_o.pend_tail     = 6'd0;
        st_o.prev_class    = cls;
      end
      st_o.win  = st_i.win >> {used, 3'b000};
      st_o.fill = st_i.fill - used;
    end
  end

endmodule

// ===== rtl/core/pinyin_syllable_segmenter_unit.sv =====
// Top level: pinyin syllable segmenter with lookahead window and result register.
`timescale 1ns / 1ps

//  channel   dir  beat payload
//  in_bus    in   char_code[7:0], end_of_text
//  out_bus   out  syllable_valid, head_part[5:0], has_tail, tail_part[5:0], run_last
//
//  One byte per cycle while out_bus is not stalled; each byte gives at most one beat in the next cycle.
//  A byte with end_of_text starts a flush, with in_bus.ready low: one window match per
//  cycle until the window is empty, then the closing beat.
//  rst_n (synchronous, active low) empties the window and drops any pending syllable.
//  A stalled out_bus holds the result register and stops input and flush.

module pinyin_syllable_segmenter_unit (
  input  logic       clk,
  input  logic       rst_n,
  pss_in_if.sink     in_bus,
  pss_out_if.source  out_bus
);

  pss_pkg::pss_state_t  st_r, src, step_st;
  pss_pkg::pss_result_t step_res, out_r, res_nxt;
  logic                 flush_r;
  logic                 out_valid_r;
  logic                 stall, accept, step_en, do_match, step_emit, emit_nxt, last_flush;
  logic [4:0]           ins_sh;

  assign stall        = out_valid_r && !out_bus.ready;
  assign in_bus.ready = !flush_r && !stall;
  assign accept       = in_bus.valid && in_bus.ready;
  assign step_en      = flush_r ? !stall : accept;
  assign last_flush   = flush_r && (st_r.fill == 3'd0);
  assign ins_sh       = {st_r.fill[1:0], 3'b000};

  always_comb begin
    src = st_r;
    if (!flush_r) begin
      src.win  = (st_r.win & ~(32'hFF << ins_sh)) | ({24'd0, in_bus.char_code} << ins_sh);
      src.fill = st_r.fill + 3'd1;
    end
  end

  assign do_match = flush_r ? (st_r.fill != 3'd0)
                            : (!in_bus.end_of_text && st_r.fill == 3'd3);

  pss_step u_step (
    .st_i (src),
    .en   (do_match),
    .st_o (step_st),
    .emit (step_emit),
    .res  (step_res)
  );

  always_comb begin
    if (last_flush) begin
      emit_nxt               = 1'b1;
      res_nxt.syllable_valid = st_r.pend_valid;
      res_nxt.head_part      = st_r.pend_head;
      res_nxt.has_tail       = st_r.pend_has_tail;
      res_nxt.tail_part      = st_r.pend_tail;
      res_nxt.run_last       = 1'b1;
    end else begin
      emit_nxt = step_emit;
      res_nxt  = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pss_pkg::PSS_STATE_RST;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en) begin
        if (last_flush) begin
          st_r    <= pss_pkg::PSS_STATE_RST;
          flush_r <= 1'b0;
        end else begin
          st_r <= step_st;
          if (!flush_r) begin
            flush_r <= in_bus.end_of_text;
          end
        end
      end
      if (!stall) begin
        out_valid_r <= step_en && emit_nxt;
      end
    end
  end

  // hold payload while the beat waits
  always_ff @(posedge clk) begin
    if (!stall) begin
      out_r <= res_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.syllable_valid = out_r.syllable_valid;
  assign out_bus.head_part      = out_r.head_part;
  assign out_bus.has_tail       = out_r.has_tail;
  assign out_bus.tail_part      = out_r.tail_part;
  assign out_bus.run_last       = out_r.run_last;

endmodule
